// ===== rtl/sact_pkg.sv =====
// Shared types and constants of the set-associative tag store.
package sact_pkg;

    localparam int SETS_DEF     = 64;
    localparam int WAYS_DEF     = 8;
    localparam int TAG_BITS_DEF = 20;

    localparam int SET_IN_BITS  = 6;
    localparam int TAG_IN_BITS  = 20;
    localparam int S_DATA_BITS  = 32;
    localparam int M_DATA_BITS  = 8;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_REPLACE_POLICY = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAYS_LOG2      = 8'd1;

    localparam logic [1:0] CLS_HIT        = 2'd0;
    localparam logic [1:0] CLS_COMPULSORY = 2'd1;
    localparam logic [1:0] CLS_CONFLICT   = 2'd2;
    localparam logic [1:0] CLS_CAPACITY   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;   // latch the accepted word, start the row read
        logic compute;   // row data valid: resolve hit and victim
        logic writeback; // write the updated row
        logic load_out;  // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // largest k with (1 << k) <= n
    function automatic int floor_log2(input int n);
        int k;
        k = 0;
        while ((2 << k) <= n) k++;
        return k;
    endfunction

endpackage

// ===== rtl/sact_ram.sv =====
// Generic RAM with one write port and one read port, registered read.
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sact_ctrl.sv =====
// Access sequencer: accept, row read, resolve, write back.
module sact_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sact_pkg::status_t status,
    output sact_pkg::cmd_t    cmd
);
    sact_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sact_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sact_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = sact_pkg::ST_LOOKUP;
            end
            sact_pkg::ST_LOOKUP: state_next = sact_pkg::ST_UPDATE;
            sact_pkg::ST_UPDATE: begin
                if (status.out_free) state_next = sact_pkg::ST_IDLE;
            end
            default: state_next = sact_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            sact_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            sact_pkg::ST_LOOKUP: cmd.compute = 1'b1;
            sact_pkg::ST_UPDATE: begin
                // row write repeats while stalled; same data each time
                cmd.writeback = 1'b1;
                cmd.load_out  = status.out_free;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/sact_dp.sv =====
// Datapath: row store, tag compare, LRU/PLRU victim and update, result register.
module sact_dp #(
    parameter int SETS     = sact_pkg::SETS_DEF,
    parameter int WAYS     = sact_pkg::WAYS_DEF,
    parameter int TAG_BITS = sact_pkg::TAG_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sact_pkg::cmd_t                      cmd,
    output sact_pkg::status_t                   status,
    input  logic [sact_pkg::S_DATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sact_pkg::M_DATA_BITS-1:0]    m_tdata,
    input  logic                                cfg_valid,
    input  logic [sact_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sact_pkg::CFG_DAT_BITS-1:0]   cfg_data
);
    localparam int SB     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LG_MAX = sact_pkg::floor_log2(WAYS);
    localparam int PB     = (WAYS > 1) ? WAYS - 1 : 1;
    localparam int TOFF   = 0;
    localparam int VOFF   = WAYS * TAG_BITS;
    localparam int DOFF   = VOFF + WAYS;
    localparam int LOFF   = DOFF + WAYS;
    localparam int POFF   = LOFF + WAYS * WB;
    localparam int RW     = POFF + PB;
    localparam int FULL   = SETS * WAYS;
    localparam int FB     = $clog2(FULL + 1);

    // word in
    logic [sact_pkg::SET_IN_BITS-1:0] in_set;
    logic [TAG_BITS-1:0]              in_tag;
    assign in_set = s_tdata[sact_pkg::SET_IN_BITS-1:0];
    assign in_tag = TAG_BITS'(s_tdata[sact_pkg::SET_IN_BITS +: sact_pkg::TAG_IN_BITS]);

    // set index wraps modulo SETS through a constant table
    logic [SB-1:0] set_map [2**sact_pkg::SET_IN_BITS];
    for (genvar g = 0; g < 2**sact_pkg::SET_IN_BITS; g++) begin : g_map
        assign set_map[g] = SB'(g % SETS);
    end

    logic          policy_reg;
    logic [1:0]    lg_cfg_reg;
    logic [SB-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic          wr_reg;
    logic [SETS-1:0] rowv_reg;
    logic [FB-1:0] fill_reg, fill_next;
    logic [RW-1:0] row_reg, row_next;
    logic          hit_reg, hit_next;
    logic [WB-1:0] vic_reg, vic_next;
    logic          dev_reg, dev_next;
    logic [1:0]    cls_reg, cls_next;
    logic          out_v_reg;
    logic [sact_pkg::M_DATA_BITS-1:0] out_reg;
    logic [RW-1:0] ram_rdata;

    sact_ram #(.WIDTH(RW), .DEPTH(SETS)) u_rows (
        .aclk  (aclk),
        .we    (cmd.writeback),
        .waddr (set_reg),
        .wdata (row_reg),
        .raddr (set_map[in_set]),
        .rdata (ram_rdata)
    );

    // ways in use, clipped to the largest power of two not above WAYS
    logic [1:0] lg_use;
    int         w_use;
    always_comb begin
        lg_use = (int'(lg_cfg_reg) > LG_MAX) ? 2'(LG_MAX) : lg_cfg_reg;
        w_use  = 1 << lg_use;
    end

    always_comb begin
        logic [RW-1:0] row;
        logic          found;
        int            way;
        int            p;
        int            n;
        logic [WB-1:0] ent;
        logic [WB-1:0] lru_v;
        logic [WB-1:0] plru_v;
        logic [PB-1:0] tree;
        logic [FB-1:0] total;
        logic          v_e;
        logic [WB-1:0] node_up;

        v_e     = 1'b0;
        node_up = '0;
        row = ram_rdata;
        if (!rowv_reg[set_reg]) begin
            row = '0;
            for (int i = 0; i < WAYS; i++) begin
                row[LOFF + i*WB +: WB] = WB'(i);
            end
        end

        found = 1'b0;
        way   = 0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found && i < w_use && row[VOFF + i] &&
                row[TOFF + i*TAG_BITS +: TAG_BITS] == tag_reg) begin
                found = 1'b1;
                way   = i;
            end
        end

        lru_v = '0;
        for (int i = 0; i < WAYS; i++) begin
            ent = row[LOFF + i*WB +: WB];
            if (int'(ent) < w_use) lru_v = ent;
        end

        tree = row[POFF +: PB];
        n = 0;
        for (int k = 0; k < LG_MAX; k++) begin
            if (n + 1 < w_use) n = 2*n + 1 + int'(tree[n[WB-1:0]]);
        end
        plru_v = WB'(n - (w_use - 1));

        total    = FB'(SETS << lg_use);
        dev_next = 1'b0;
        cls_next = sact_pkg::CLS_HIT;
        fill_next = fill_reg;
        row_next = row;
        if (found) begin
            if (wr_reg) row_next[DOFF + way] = 1'b1;
        end else begin
            if (w_use == 1)      way = 0;
            else if (policy_reg) way = int'(plru_v);
            else                 way = int'(lru_v);
            v_e = row[VOFF + way];
            if (fill_reg >= total) cls_next = sact_pkg::CLS_CAPACITY;
            else if (v_e)          cls_next = sact_pkg::CLS_CONFLICT;
            else                   cls_next = sact_pkg::CLS_COMPULSORY;
            if (!v_e && fill_reg < FB'(FULL)) fill_next = fill_reg + 1'b1;
            dev_next = v_e & row[DOFF + way];
            row_next[TOFF + way*TAG_BITS +: TAG_BITS] = tag_reg;
            row_next[VOFF + way] = 1'b1;
            row_next[DOFF + way] = wr_reg;
        end
        hit_next = found;
        vic_next = WB'(way);

        // move the accessed way to the front of the recency list
        p = WAYS - 1;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (row[LOFF + i*WB +: WB] == WB'(way)) p = i;
        end
        for (int i = 1; i < WAYS; i++) begin
            if (i <= p) row_next[LOFF + i*WB +: WB] = row[LOFF + (i-1)*WB +: WB];
        end
        row_next[LOFF +: WB] = WB'(way);

        // point the path nodes away from the accessed way
        n = way + w_use - 1;
        for (int k = 0; k < LG_MAX; k++) begin
            if (n > 0) begin
                node_up       = WB'((n - 1) >> 1);
                tree[node_up] = n[0];
                n = (n - 1) >> 1;
            end
        end
        if (WAYS > 1) row_next[POFF +: PB] = tree;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
            lg_cfg_reg <= 2'd3;
            rowv_reg   <= '0;
            fill_reg   <= '0;
            out_v_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == sact_pkg::REG_REPLACE_POLICY) begin
                policy_reg <= cfg_data[0];
            end
            if (cfg_valid && cfg_index == sact_pkg::REG_WAYS_LOG2) begin
                lg_cfg_reg <= cfg_data[1:0];
            end
            if (cmd.compute) fill_reg <= fill_next;
            if (cmd.writeback) rowv_reg[set_reg] <= 1'b1;
            if (cmd.load_out) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            set_reg <= set_map[in_set];
            tag_reg <= in_tag;
            wr_reg  <= s_tdata[sact_pkg::SET_IN_BITS + sact_pkg::TAG_IN_BITS];
        end
        if (cmd.compute) begin
            row_reg <= row_next;
            hit_reg <= hit_next;
            vic_reg <= vic_next;
            dev_reg <= dev_next;
            cls_reg <= cls_next;
        end
        if (cmd.load_out) begin
            out_reg <= {1'b0, cls_reg, dev_reg, 3'(vic_reg), hit_reg};
        end
    end

    assign status.out_free = !out_v_reg || m_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
endmodule

// ===== rtl/set_assoc_cache_tag_replacement.sv =====
// Top level of the set-associative cache tag store with LRU / tree-PLRU replacement.
// Each access word passes in order through accept (row read from the set RAM), hit/victim
// resolve, and row write back with result load into the output register; no new access is
// taken until the previous one has finished write-back. While an earlier result still waits on
// m_tready, write-back repeats and holds off the input until the result register frees up. Set
// state lives in one RAM row per set (tags, valid, dirty, recency list, PLRU bits); a per-set
// flag marks rows never written, which read as the reset row, so no clearing pass follows reset.
// Config writes are always ready and must come only while the block is idle.
module set_assoc_cache_tag_replacement #(
    parameter int SETS     = sact_pkg::SETS_DEF,
    parameter int WAYS     = sact_pkg::WAYS_DEF,
    parameter int TAG_BITS = sact_pkg::TAG_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] set_index, [25:6] tag, [26] write_access, [31:27] zero
    input  logic [sact_pkg::S_DATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] hit, [3:1] victim_way, [4] dirty_evicted, [6:5] miss_class, [7] zero
    output logic [sact_pkg::M_DATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sact_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [sact_pkg::CFG_DAT_BITS-1:0] cfg_data
);
    sact_pkg::cmd_t    cmd;
    sact_pkg::status_t status;

    assign cfg_ready = 1'b1;

    sact_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sact_dp #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule
